>>> rtl/ffba_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// ffba_pkg
// Shared types and codes of the first-fit block allocator.
// -----------------------------------------------------------------------------
package ffba_pkg;

  localparam logic [1:0] FuncAlloc = 2'd0;
  localparam logic [1:0] FuncFree  = 2'd1;
  localparam logic [1:0] FuncClear = 2'd2;

  localparam logic [1:0] StatusDone     = 2'd0;
  localparam logic [1:0] StatusNoMemory = 2'd1;
  localparam logic [1:0] StatusNotFound = 2'd2;

  // One list entry: start offset, length and free mark.
  typedef struct packed {
    logic [15:0] start;
    logic [15:0] len;
    logic        free;
  } entry_t;

endpackage
`default_nettype wire

>>> rtl/ffba_list_mem.sv
`default_nettype none
// -----------------------------------------------------------------------------
// ffba_list_mem
// Block list storage: one write port, one registered read port.
// -----------------------------------------------------------------------------
module ffba_list_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  wire                   clk_i,
  input  wire                   we_i,
  input  wire [AddrW-1:0]       waddr_i,
  input  ffba_pkg::entry_t      wdata_i,
  input  wire [AddrW-1:0]       raddr_i,
  output ffba_pkg::entry_t      rdata_o
);

  ffba_pkg::entry_t mem_q [Depth];

  // Synchronous write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> rtl/first_fit_block_allocator.sv
`default_nettype none
// -----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over an ordered block list held in one memory.
// A request scans the list entry by entry and may shift entries up for an insert
// or down for an erase. One request at a time: no new transfer is taken
// until the response transfer has left.
// The list memory has one read and one write port; the sequencer walks it.
// Reset leaves the list as one free block of pool_size: entry zero is written
// in the first cycle after reset, while the input is held off. The other
// entries are never read before being written, so no clearing pass is needed.
// -----------------------------------------------------------------------------
module first_fit_block_allocator #(
  parameter int unsigned MAX_BLOCKS = 64,
  parameter int unsigned SPLIT_MIN  = 4
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: [15:0] request_size, [31:16] free_offset
  input  wire  [31:0] s_axis_tdata,
  // tuser: [1:0] func
  input  wire  [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // tdata: [15:0] alloc_offset, [17:16] status, zero filled to 24 bits
  output logic [23:0] m_axis_tdata,
  input  wire         cfg_we_i,
  input  wire  [15:0] cfg_wdata_i
);

  localparam int unsigned AW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [CW-1:0] CntMax = CW'(MAX_BLOCKS);
  localparam logic [16:0] SplitMin = 17'(SPLIT_MIN);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;  // read issued, wait
  localparam logic [3:0] S_CHK   = 4'd2;  // check read data
  localparam logic [3:0] S_INS_R = 4'd3;  // shift up: read
  localparam logic [3:0] S_INS_W = 4'd4;  // shift up: write
  localparam logic [3:0] S_NXT_R = 4'd5;  // read next neighbor
  localparam logic [3:0] S_NXT_C = 4'd6;
  localparam logic [3:0] S_PRV_R = 4'd7;
  localparam logic [3:0] S_PRV_C = 4'd8;
  localparam logic [3:0] S_ER_R  = 4'd9;  // shift down: read
  localparam logic [3:0] S_ER_W  = 4'd10; // shift down: write
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0]    state_q, state_d;
  logic [15:0]   pool_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;     // found entry / cursor
  logic [CW-1:0] ptr_q, ptr_d;     // shift pointer
  logic [1:0]    func_q, func_d;
  logic [15:0]   req_q, req_d, off_q, off_d;
  logic [15:0]   res_q, res_d;
  logic [1:0]    st_q, st_d;
  logic          oval_q, oval_d;
  logic          prev_pass_q, prev_pass_d; // second erase is for previous merge
  ffba_pkg::entry_t cur_q, cur_d;  // the found entry as modified
  logic [15:0]   ins_start_q, ins_start_d, ins_len_q, ins_len_d;
  logic          init_q;           // entry zero still to be written

  logic          we;
  logic [AW-1:0] waddr, raddr;
  ffba_pkg::entry_t wdata, rdata;

  ffba_list_mem #(.Depth(MAX_BLOCKS), .AddrW(AW)) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE) && !oval_q && !init_q;
  assign m_axis_tvalid = oval_q;
  assign m_axis_tdata  = {6'd0, st_q, res_q};

  // Sequencer over the list; one compare/add unit per step.
  always_comb begin
    logic [16:0] sum;
    state_d = state_q; cnt_d = cnt_q; idx_d = idx_q; ptr_d = ptr_q;
    func_d = func_q; req_d = req_q; off_d = off_q; res_d = res_q; st_d = st_q;
    oval_d = oval_q; prev_pass_d = prev_pass_q; cur_d = cur_q;
    ins_start_d = ins_start_q; ins_len_d = ins_len_q;
    we = 1'b0; waddr = '0; wdata = '0; raddr = idx_q[AW-1:0];
    sum = '0;
    if (oval_q && m_axis_tready) begin
      oval_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (init_q) begin
          // First cycle after reset: one free block covering the pool.
          we = 1'b1; waddr = '0;
          wdata = '{start: 16'd0, len: pool_q, free: 1'b1};
        end else if (s_axis_tvalid && s_axis_tready) begin
          func_d = s_axis_tuser;
          req_d  = s_axis_tdata[15:0];
          off_d  = s_axis_tdata[31:16];
          res_d  = '0;
          st_d   = ffba_pkg::StatusDone;
          idx_d  = '0;
          raddr  = '0;
          unique case (s_axis_tuser)
            ffba_pkg::FuncAlloc: begin
              st_d = ffba_pkg::StatusNoMemory; state_d = S_SCAN;
            end
            ffba_pkg::FuncFree: begin
              st_d = ffba_pkg::StatusNotFound; state_d = S_SCAN;
            end
            ffba_pkg::FuncClear: begin
              we = 1'b1; waddr = '0;
              wdata = '{start: 16'd0, len: pool_q, free: 1'b1};
              cnt_d = CW'(1); state_d = S_OUT;
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_SCAN: begin
        if (idx_q >= cnt_q) begin
          state_d = S_OUT;
        end else begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        cur_d = rdata;
        if (func_q == ffba_pkg::FuncAlloc) begin
          if (rdata.free && rdata.len >= req_q) begin
            res_d = rdata.start;
            st_d  = ffba_pkg::StatusDone;
            if ({1'b0, rdata.len} > ({1'b0, req_q} + SplitMin) && cnt_q < CntMax) begin
              we = 1'b1; waddr = idx_q[AW-1:0];
              wdata = '{start: rdata.start, len: req_q, free: 1'b0};
              ins_start_d = rdata.start + req_q;
              ins_len_d   = rdata.len - req_q;
              ptr_d = cnt_q;
              state_d = S_INS_R;
            end else begin
              we = 1'b1; waddr = idx_q[AW-1:0];
              wdata = '{start: rdata.start, len: rdata.len, free: 1'b0};
              state_d = S_OUT;
            end
          end else begin
            idx_d = idx_q + CW'(1); raddr = idx_d[AW-1:0]; state_d = S_SCAN;
          end
        end else begin
          if (rdata.start == off_q) begin
            st_d = ffba_pkg::StatusDone;
            cur_d.free = 1'b1;
            we = 1'b1; waddr = idx_q[AW-1:0];
            wdata = '{start: rdata.start, len: rdata.len, free: 1'b1};
            raddr = AW'(idx_q + CW'(1));
            state_d = S_NXT_R;
          end else begin
            idx_d = idx_q + CW'(1); raddr = idx_d[AW-1:0]; state_d = S_SCAN;
          end
        end
      end
      // Shift entries idx+1..cnt-1 up by one, from the top down.
      S_INS_R: begin
        if (ptr_q == idx_q + CW'(1)) begin
          we = 1'b1; waddr = ptr_q[AW-1:0];
          wdata = '{start: ins_start_q, len: ins_len_q, free: 1'b1};
          cnt_d = cnt_q + CW'(1);
          state_d = S_OUT;
        end else begin
          raddr = AW'(ptr_q - CW'(1));
          state_d = S_INS_W;
        end
      end
      S_INS_W: begin
        we = 1'b1; waddr = ptr_q[AW-1:0]; wdata = rdata;
        ptr_d = ptr_q - CW'(1);
        state_d = S_INS_R;
      end
      S_NXT_R: begin
        raddr = AW'(idx_q + CW'(1));
        state_d = S_NXT_C;
      end
      S_NXT_C: begin
        if (idx_q + CW'(1) < cnt_q && rdata.free) begin
          sum = {1'b0, cur_q.len} + {1'b0, rdata.len};
          cur_d.len = sum[15:0];
          we = 1'b1; waddr = idx_q[AW-1:0];
          wdata = '{start: cur_q.start, len: sum[15:0], free: 1'b1};
          ptr_d = idx_q + CW'(1);
          prev_pass_d = 1'b0;
          state_d = S_ER_R;
        end else begin
          raddr = AW'(idx_q - CW'(1));
          state_d = S_PRV_R;
        end
      end
      S_PRV_R: begin
        raddr = AW'(idx_q - CW'(1));
        state_d = (idx_q == '0) ? S_OUT : S_PRV_C;
      end
      S_PRV_C: begin
        if (rdata.free) begin
          sum = {1'b0, rdata.len} + {1'b0, cur_q.len};
          we = 1'b1; waddr = AW'(idx_q - CW'(1));
          wdata = '{start: rdata.start, len: sum[15:0], free: 1'b1};
          ptr_d = idx_q;
          prev_pass_d = 1'b1;
          state_d = S_ER_R;
        end else begin
          state_d = S_OUT;
        end
      end
      // Erase entry ptr: shift the tail down by one.
      S_ER_R: begin
        if (ptr_q + CW'(1) >= cnt_q) begin
          cnt_d = cnt_q - CW'(1);
          state_d = prev_pass_q ? S_OUT : S_PRV_R;
        end else begin
          raddr = AW'(ptr_q + CW'(1));
          state_d = S_ER_W;
        end
      end
      S_ER_W: begin
        we = 1'b1; waddr = ptr_q[AW-1:0]; wdata = rdata;
        ptr_d = ptr_q + CW'(1);
        state_d = S_ER_R;
      end
      S_OUT: begin
        if (!oval_q) begin
          oval_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers and pool size.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= CW'(1);
      oval_q  <= 1'b0;
      pool_q  <= 16'hFFFF;
      idx_q   <= '0;
      ptr_q   <= '0;
      prev_pass_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      oval_q  <= oval_d;
      idx_q   <= idx_d;
      ptr_q   <= ptr_d;
      prev_pass_q <= prev_pass_d;
      if (cfg_we_i) begin
        pool_q <= cfg_wdata_i;
      end
    end
  end

  // Entry zero after reset: tracked by a flag, written on first idle cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= 1'b1;
    end else begin
      init_q <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    func_q <= func_d; req_q <= req_d; off_q <= off_d;
    res_q <= res_d; st_q <= st_d; cur_q <= cur_d;
    ins_start_q <= ins_start_d; ins_len_q <= ins_len_d;
  end

endmodule
`default_nettype wire

>>> tb/sv/tb_first_fit_block_allocator.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_first_fit_block_allocator
// Drives allocate, free and clear requests into the allocator, predicts every
// response with a behavioral copy of the block list, and compares each output
// transfer with the oldest prediction under varying input and output idling.
// -----------------------------------------------------------------------------
module tb_first_fit_block_allocator;

  localparam int unsigned ListDepth = 64;
  localparam int unsigned SplitMin  = 4;
  localparam logic [1:0]  FuncUnused = 2'd3;
  localparam int unsigned CycleLimit = 3000000;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] req_size;
    logic [15:0] free_off;
  } request_t;

  typedef struct packed {
    logic [15:0] offset;
    logic [1:0]  status;
  } response_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  first_fit_block_allocator dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  // Predicted allocator state.
  logic [15:0] pool_len;
  logic [15:0] blk_start [ListDepth];
  logic [15:0] blk_len [ListDepth];
  logic        blk_free [ListDepth];
  int unsigned blk_count;

  request_t    pending_reqs[$];
  response_t   expected_resps[$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_off_cycles;

  // Acceptance seen at the last rising edge, used by the driver.
  logic s_axis_tready_q;

  // Live offsets handed out by the predictor, used to aim free requests.
  logic [15:0] live_offsets[$];

  function automatic void list_reset();
    for (int i = 0; i < ListDepth; i++) begin
      blk_start[i] = '0;
      blk_len[i] = '0;
      blk_free[i] = 1'b0;
    end
    blk_len[0] = pool_len;
    blk_free[0] = 1'b1;
    blk_count = 1;
  endfunction

  function automatic void list_remove(int unsigned at);
    for (int unsigned i = at; i + 1 < blk_count; i++) begin
      blk_start[i] = blk_start[i + 1];
      blk_len[i] = blk_len[i + 1];
      blk_free[i] = blk_free[i + 1];
    end
    blk_count--;
    blk_start[blk_count] = '0;
    blk_len[blk_count] = '0;
    blk_free[blk_count] = 1'b0;
  endfunction

  function automatic response_t predict_allocator(request_t r);
    response_t res;
    bit        hit;
    res = '0;
    hit = 0;
    case (r.func)
      ffba_pkg::FuncAlloc: begin
        res.status = ffba_pkg::StatusNoMemory;
        for (int unsigned i = 0; i < blk_count && !hit; i++) begin
          if (blk_free[i] && blk_len[i] >= r.req_size) begin
            hit = 1;
            res.offset = blk_start[i];
            res.status = ffba_pkg::StatusDone;
            blk_free[i] = 1'b0;
            if (32'(blk_len[i]) > 32'(r.req_size) + SplitMin && blk_count < ListDepth) begin
              // Open a slot after the block for the free remainder.
              for (int unsigned j = blk_count; j > i + 1; j--) begin
                blk_start[j] = blk_start[j - 1];
                blk_len[j] = blk_len[j - 1];
                blk_free[j] = blk_free[j - 1];
              end
              blk_start[i + 1] = blk_start[i] + r.req_size;
              blk_len[i + 1] = blk_len[i] - r.req_size;
              blk_free[i + 1] = 1'b1;
              blk_len[i] = r.req_size;
              blk_count++;
            end
          end
        end
      end
      ffba_pkg::FuncFree: begin
        res.status = ffba_pkg::StatusNotFound;
        for (int unsigned i = 0; i < blk_count && !hit; i++) begin
          if (blk_start[i] == r.free_off) begin
            hit = 1;
            res.status = ffba_pkg::StatusDone;
            blk_free[i] = 1'b1;
            // Merge with the next block, then with the previous one.
            if (i + 1 < blk_count && blk_free[i + 1]) begin
              blk_len[i] = blk_len[i] + blk_len[i + 1];
              list_remove(i + 1);
            end
            if (i > 0 && blk_free[i - 1]) begin
              blk_len[i - 1] = blk_len[i - 1] + blk_len[i];
              list_remove(i);
            end
          end
        end
      end
      ffba_pkg::FuncClear: list_reset();
      default: ;
    endcase
    return res;
  endfunction

  // Random request: mostly allocates of small sizes and frees of live offsets.
  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    r.req_size = 16'($urandom);
    r.free_off = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      r.func = ffba_pkg::FuncAlloc;
      case ($urandom_range(0, 9))
        0:       r.req_size = 16'($urandom);
        1:       r.req_size = 16'($urandom_range(0, 6));
        default: r.req_size = 16'($urandom_range(1, 3000));
      endcase
    end else if (pick < 88) begin
      r.func = ffba_pkg::FuncFree;
      if (live_offsets.size() > 0 && $urandom_range(0, 9) < 8)
        r.free_off = live_offsets[$urandom_range(0, live_offsets.size() - 1)];
    end else if (pick < 92) begin
      r.func = ffba_pkg::FuncClear;
    end else if (pick < 95) begin
      r.func = FuncUnused;
    end else begin
      r.func = ffba_pkg::FuncAlloc;
      r.req_size = 16'($urandom_range(0, 40));
    end
    return r;
  endfunction

  // Queues a request; for an allocate, adds a random offset as an extra free target while fewer than 200 are held.
  task automatic push_request(request_t r);
    pending_reqs = {pending_reqs, r};
    if (r.func == ffba_pkg::FuncAlloc && live_offsets.size() < 200)
      live_offsets = {live_offsets, 16'($urandom_range(0, 65535))};
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || expected_resps.size() > 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_pool(logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    pool_len = val;
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Driver: presents queued requests at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((!s_axis_tvalid || s_axis_tready_q) && pending_reqs.size() > 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        request_t r;
        r = pending_reqs.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {r.free_off, r.req_size};
        s_axis_tuser <= r.func;
      end else if (s_axis_tvalid && s_axis_tready_q) begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, and long hold-offs counted down here.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Monitor: predicts on input transfers and checks output transfers.
  always @(posedge clk_i) begin
    s_axis_tready_q <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      if (s_axis_tvalid && s_axis_tready) begin
        request_t  r;
        response_t p;
        r.func = s_axis_tuser;
        r.req_size = s_axis_tdata[15:0];
        r.free_off = s_axis_tdata[31:16];
        p = predict_allocator(r);
        expected_resps = {expected_resps, p};
        if (r.func == ffba_pkg::FuncAlloc && p.status == ffba_pkg::StatusDone &&
            live_offsets.size() < 200)
          live_offsets = {live_offsets, p.offset};
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_resps.size() == 0) begin
          $display("%0t: unexpected response %h", $time, m_axis_tdata);
          error_count <= error_count + 1;
        end else begin
          response_t e;
          e = expected_resps.pop_front();
          if (m_axis_tdata[15:0] !== e.offset || m_axis_tdata[17:16] !== e.status ||
              m_axis_tdata[23:18] !== '0) begin
            $display("%0t: mismatch expected offset %h status %0d, got offset %h status %0d",
                     $time, e.offset, e.status, m_axis_tdata[15:0], m_axis_tdata[17:16]);
            error_count <= error_count + 1;
          end
        end
      end
      if (cycle_count > CycleLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    request_t r;
    error_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;
    pool_len = 16'hFFFF;
    list_reset();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed requests covering extremes and corner cases.
    push_request('{ffba_pkg::FuncAlloc, 16'd0, 16'd0});
    push_request('{ffba_pkg::FuncAlloc, 16'd100, 16'hFFFF});
    push_request('{ffba_pkg::FuncAlloc, 16'hFFFF, 16'd0});
    push_request('{ffba_pkg::FuncAlloc, 16'd3, 16'd0});
    push_request('{FuncUnused, 16'hFFFF, 16'hFFFF});
    push_request('{ffba_pkg::FuncFree, 16'd0, 16'd1234});
    push_request('{ffba_pkg::FuncFree, 16'd0, 16'd100});
    push_request('{ffba_pkg::FuncFree, 16'd0, 16'd100});
    push_request('{ffba_pkg::FuncFree, 16'd0, 16'd0});
    push_request('{ffba_pkg::FuncFree, 16'd0, 16'd0});
    push_request('{ffba_pkg::FuncClear, 16'hFFFF, 16'hFFFF});
    push_request('{ffba_pkg::FuncAlloc, 16'hFFFF, 16'd0});
    push_request('{ffba_pkg::FuncAlloc, 16'd0, 16'd0});
    push_request('{ffba_pkg::FuncFree, 16'd0, 16'd0});
    push_request('{ffba_pkg::FuncClear, 16'd0, 16'd0});
    wait_drained();

    // Small pool, list filled with one-unit blocks until it is full.
    write_pool(16'd200);
    push_request('{ffba_pkg::FuncClear, 16'd0, 16'd0});
    for (int i = 0; i < 70; i++) push_request('{ffba_pkg::FuncAlloc, 16'd1, 16'hFFFF});
    push_request('{ffba_pkg::FuncAlloc, 16'd1, 16'd0});
    hold_off_cycles = 2000;
    wait_drained();

    // Random phases with different idling.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  write_pool(16'd0);     end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  write_pool(16'd5000);  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; write_pool(16'hFFFF);  end
        3: begin send_idle_pct = 26; recv_stall_pct = 26; write_pool(16'd300);   end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; write_pool(16'd20000); end
      endcase
      push_request('{ffba_pkg::FuncClear, 16'd0, 16'd0});
      live_offsets.delete();
      for (int i = 0; i < 225; i++) begin
        r = random_request();
        pending_reqs = {pending_reqs, r};
      end
      if (ph == 3) hold_off_cycles = 3000;
      wait_drained();
    end

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/ffba_pkg.sv
rtl/ffba_list_mem.sv
rtl/first_fit_block_allocator.sv
tb/sv/tb_first_fit_block_allocator.sv
